FILE: hw/rtl/mops_pkg.sv
// package for the most-overdue poll scheduler: item types, codes and constants
// no dependencies; used by mops_cell and most_overdue_poll_scheduler
`default_nettype none

package mops_pkg;

  localparam int NODE_COUNT = 16;
  localparam int BENCH_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int IVL_MS_W   = 26;

  localparam logic [31:0] TIMEOUT_RST = 32'd2000;
  localparam logic [IVL_MS_W-1:0] MS_PER_S = IVL_MS_W'(1000);

  localparam logic [CFG_IDX_W-1:0] CFG_REPLY_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BENCH_MASK    = 2'd1;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_SENT   = 2'd1,
    MODE_RETIME = 2'd2,
    MODE_HEARD  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_POLL   = 2'd1,
    ACT_MISSED = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_SENT   = 2'd1,
    CMD_RETIME = 2'd2,
    CMD_HEARD  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_APPLY,
    S_SCAN,
    S_DONE
  } state_e;

  typedef struct packed {
    mode_e       mode;
    logic [3:0]  node_index;
    logic [15:0] poll_sec;
    logic [31:0] now_ms;
    logic        start_ok;
  } in_t;

  typedef struct packed {
    action_e     action;
    logic [3:0]  chosen_node;
    logic        answer_valid;
    logic [31:0] rtt_ms;
    logic [31:0] sent_count;
    logic [31:0] missed_count;
    logic [31:0] answered_count;
  } out_t;

  // broadcast to every row cell
  typedef struct packed {
    cmd_e                op;
    logic [31:0]         now;
    logic [IVL_MS_W-1:0] ivl_ms;
  } cmd_t;

  // best-so-far carried down the chain
  typedef struct packed {
    logic        vld;
    logic        found;
    logic [31:0] late;
  } scan_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mops_cell.sv
// one row cell: due time, sent time, heard flag, and one stage of the scan chain
// depends on mops_pkg
`default_nettype none

module mops_cell #(
  parameter int IdxW    = 4,
  parameter int CellIdx = 0
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    bench_i,
  input  wire                    sel_i,
  input  mops_pkg::cmd_t         cmd_i,
  input  mops_pkg::scan_t        scan_i,
  input  wire  [IdxW-1:0]        idx_i,
  output mops_pkg::scan_t        scan_o,
  output logic [IdxW-1:0]        idx_o
);
  import mops_pkg::*;

  logic [31:0] due_q, due_d;
  logic [31:0] sent_q, sent_d;
  logic        due_vld_q, due_vld_d;
  logic        heard_q, heard_d;
  logic        enrolled;
  logic [31:0] diff;
  logic [31:0] late;
  logic        cand;
  logic        take;
  scan_t       scan_q, scan_d;
  logic [IdxW-1:0] idx_q, idx_d;

  assign enrolled = !bench_i || heard_q;

  always_comb begin
    due_d     = due_q;
    sent_d    = sent_q;
    due_vld_d = due_vld_q;
    heard_d   = heard_q;
    if (sel_i) begin
      case (cmd_i.op)
        CMD_SENT: begin
          due_d     = cmd_i.now + {{(32-IVL_MS_W){1'b0}}, cmd_i.ivl_ms};
          sent_d    = cmd_i.now;
          due_vld_d = 1'b1;
        end
        CMD_RETIME: begin
          if (due_vld_q) begin
            due_d = sent_q + {{(32-IVL_MS_W){1'b0}}, cmd_i.ivl_ms};
          end
        end
        CMD_HEARD: begin
          heard_d = 1'b1;
          if (!enrolled) begin
            due_vld_d = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // lateness against the current time; never-polled rows rank highest
  assign diff = cmd_i.now - due_q;
  assign cand = enrolled && (!due_vld_q || !diff[31]);
  assign late = due_vld_q ? diff : 32'hFFFF_FFFF;
  assign take = scan_i.vld && cand && (!scan_i.found || (late > scan_i.late));

  always_comb begin
    scan_d = scan_i;
    idx_d  = idx_i;
    if (take) begin
      scan_d.found = 1'b1;
      scan_d.late  = late;
      idx_d        = IdxW'(CellIdx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      due_vld_q <= 1'b0;
      heard_q   <= 1'b0;
      scan_q    <= '0;
    end else begin
      due_vld_q <= due_vld_d;
      heard_q   <= heard_d;
      scan_q    <= scan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    due_q  <= due_d;
    sent_q <= sent_d;
    idx_q  <= idx_d;
  end

  assign scan_o = scan_q;
  assign idx_o  = idx_q;

endmodule

`default_nettype wire

FILE: hw/rtl/most_overdue_poll_scheduler.sv
// top level of the most-overdue poll scheduler: control, counters and the row cell chain
// depends on mops_pkg and mops_cell
//
// channel  direction  handshake                  payload
// in       in         in_valid_i / in_ready_o    in_item_i  (mops_pkg::in_t)
// out      out        out_valid_o / out_ready_i  out_item_o (mops_pkg::out_t)
// cfg      in         cfg_we_i                   cfg_index_i, cfg_data_i
//
// sent, retime, heard and ticks without a scan: S_IDLE accepts, then S_PREP, S_APPLY, S_DONE
// a tick that scans adds S_SCAN while the scan passes through each row cell of the chain
// one item is in work at a time; a new item is taken while the result waits
// a stalled output holds the next result in S_DONE until the register frees
// reset clears flags, counters, bench mask; timeout gets TIMEOUT_RST; cell times need no reset
`default_nettype none

module most_overdue_poll_scheduler #(
  parameter int NodeCount = mops_pkg::NODE_COUNT
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   in_valid_i,
  output logic                                  in_ready_o,
  input  mops_pkg::in_t                         in_item_i,
  output logic                                  out_valid_o,
  input  wire                                   out_ready_i,
  output mops_pkg::out_t                        out_item_o,
  input  wire                                   cfg_we_i,
  input  wire  [mops_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire  [mops_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import mops_pkg::*;

  localparam int IdxW = (NodeCount > 1) ? $clog2(NodeCount) : 1;

  state_e              state_q, state_d;
  in_t                 item_q;
  logic [IVL_MS_W-1:0] ivl_ms_q;
  logic [15:0]         ivl_s;
  logic [31:0]         timeout_q;
  logic [BENCH_W-1:0]  bench_q;
  logic                poll_out_q;
  logic [3:0]          out_row_q;
  logic [31:0]         last_send_q;
  logic [31:0]         cnt_sent_q, cnt_missed_q, cnt_ans_q;
  action_e             res_act_q;
  logic [3:0]          res_node_q;
  logic                res_ans_q;
  logic [31:0]         res_ans_ms_q;
  logic                out_valid_q;
  out_t                out_q;

  logic        in_range;
  logic        missed;
  logic [31:0] since_send;
  logic        scan_start;
  logic        load_out;
  cmd_t        cmd;

  scan_t           scan_w [NodeCount+1];
  logic [IdxW-1:0] idx_w  [NodeCount+1];
  logic [NodeCount-1:0] sel;

  assign in_range   = int'(item_q.node_index) < NodeCount;
  assign since_send = item_q.now_ms - last_send_q;
  assign missed     = since_send >= timeout_q;
  assign ivl_s      = (item_q.poll_sec == 16'd0) ? 16'd1 : item_q.poll_sec;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    scan_start = 1'b0;
    load_out   = 1'b0;
    cmd.op     = CMD_NONE;
    cmd.now    = item_q.now_ms;
    cmd.ivl_ms = ivl_ms_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        state_d = S_APPLY;
      end
      S_APPLY: begin
        state_d = S_DONE;
        if (item_q.mode == MODE_TICK) begin
          if (!poll_out_q && item_q.start_ok) begin
            scan_start = 1'b1;
            state_d    = S_SCAN;
          end
        end else if (in_range) begin
          unique case (item_q.mode)
            MODE_SENT:   cmd.op = CMD_SENT;
            MODE_RETIME: cmd.op = CMD_RETIME;
            MODE_HEARD:  cmd.op = CMD_HEARD;
            default:     cmd.op = CMD_NONE;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_w[NodeCount].vld) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // row cell chain
  assign scan_w[0] = '{vld: scan_start, found: 1'b0, late: 32'd0};
  assign idx_w[0]  = '0;

  for (genvar i = 0; i < NodeCount; i++) begin : g_cell
    logic bench_bit;
    if (i < BENCH_W) begin : g_bench
      assign bench_bit = bench_q[i];
      assign sel[i]    = item_q.node_index == 4'(i);
    end else begin : g_plain
      assign bench_bit = 1'b0;
      assign sel[i]    = 1'b0;
    end
    mops_cell #(
      .IdxW    (IdxW),
      .CellIdx (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .bench_i (bench_bit),
      .sel_i   (sel[i]),
      .cmd_i   (cmd),
      .scan_i  (scan_w[i]),
      .idx_i   (idx_w[i]),
      .scan_o  (scan_w[i+1]),
      .idx_o   (idx_w[i+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
    if (state_q == S_PREP) begin
      ivl_ms_q <= IVL_MS_W'({{(IVL_MS_W-16){1'b0}}, ivl_s} * MS_PER_S);
    end
    if (load_out) begin
      out_q.action         <= res_act_q;
      out_q.chosen_node    <= res_node_q;
      out_q.answer_valid   <= res_ans_q;
      out_q.rtt_ms         <= res_ans_ms_q;
      out_q.sent_count     <= cnt_sent_q;
      out_q.missed_count   <= cnt_missed_q;
      out_q.answered_count <= cnt_ans_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q    <= TIMEOUT_RST;
      bench_q      <= '0;
      poll_out_q   <= 1'b0;
      out_row_q    <= '0;
      last_send_q  <= '0;
      cnt_sent_q   <= '0;
      cnt_missed_q <= '0;
      cnt_ans_q    <= '0;
      res_act_q    <= ACT_NONE;
      res_node_q   <= '0;
      res_ans_q    <= 1'b0;
      res_ans_ms_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_REPLY_TIMEOUT: timeout_q <= cfg_data_i;
          CFG_BENCH_MASK:    bench_q   <= cfg_data_i[BENCH_W-1:0];
          default: ;
        endcase
      end

      if (state_q == S_APPLY) begin
        res_act_q    <= ACT_NONE;
        res_node_q   <= '0;
        res_ans_q    <= 1'b0;
        res_ans_ms_q <= '0;
        if (item_q.mode == MODE_TICK) begin
          if (poll_out_q && missed) begin
            poll_out_q   <= 1'b0;
            cnt_missed_q <= cnt_missed_q + 32'd1;
            res_act_q    <= ACT_MISSED;
            res_node_q   <= out_row_q;
          end
        end else if (in_range) begin
          if (item_q.mode == MODE_SENT) begin
            poll_out_q  <= 1'b1;
            out_row_q   <= item_q.node_index;
            last_send_q <= item_q.now_ms;
            cnt_sent_q  <= cnt_sent_q + 32'd1;
          end else if (item_q.mode == MODE_HEARD) begin
            if (poll_out_q && (out_row_q == item_q.node_index)) begin
              poll_out_q   <= 1'b0;
              cnt_ans_q    <= cnt_ans_q + 32'd1;
              res_ans_q    <= 1'b1;
              res_ans_ms_q <= since_send;
            end
          end
        end
      end

      if ((state_q == S_SCAN) && scan_w[NodeCount].vld && scan_w[NodeCount].found) begin
        res_act_q  <= ACT_POLL;
        res_node_q <= 4'(idx_w[NodeCount]);
      end

      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  a_scan_only_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_w[NodeCount].vld |-> (state_q == S_SCAN))
    else $error("scan result outside scan state");

  a_poll_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    poll_out_q |-> (int'(out_row_q) < NodeCount))
    else $error("outstanding row out of range");

  a_answer_no_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.answer_valid) |-> (out_item_o.action == ACT_NONE))
    else $error("answer with an action");

  a_scan_starts_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_start |-> (!poll_out_q && (state_q == S_APPLY)))
    else $error("scan started with poll outstanding");
`endif

endmodule

`default_nettype wire
